@@ rtl/mbsp_pkg.sv @@
// shared types and constants for the midi byte stream parser
package mbsp_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PAIR      = 3'd1,
    PH_SX_LEN    = 3'd2,
    PH_SX_PAY    = 3'd3,
    PH_META_TYPE = 3'd4,
    PH_META_LEN  = 3'd5,
    PH_META_SKIP = 3'd6
  } phase_t;

  // event kinds
  localparam logic [3:0] EV_NOTE_OFF   = 4'd0;
  localparam logic [3:0] EV_NOTE_ON    = 4'd1;
  localparam logic [3:0] EV_NOTE_PRESS = 4'd2;
  localparam logic [3:0] EV_CC         = 4'd3;
  localparam logic [3:0] EV_PROG       = 4'd4;
  localparam logic [3:0] EV_CHAN_PRESS = 4'd5;
  localparam logic [3:0] EV_BEND       = 4'd6;
  localparam logic [3:0] EV_SX_BYTE    = 4'd7;
  localparam logic [3:0] EV_SX_EMPTY   = 4'd8;
  localparam logic [3:0] EV_QFRAME     = 4'd9;
  localparam logic [3:0] EV_SONG_POS   = 4'd10;
  localparam logic [3:0] EV_SONG_SEL   = 4'd11;
  localparam logic [3:0] EV_TUNE       = 4'd12;
  localparam logic [3:0] EV_START      = 4'd13;
  localparam logic [3:0] EV_CONTINUE   = 4'd14;
  localparam logic [3:0] EV_STOP       = 4'd15;

  // channel message high nibbles
  localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
  localparam logic [3:0] NIB_NOTE_PRESS = 4'hA;
  localparam logic [3:0] NIB_CC         = 4'hB;
  localparam logic [3:0] NIB_PROG       = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
  localparam logic [3:0] NIB_BEND       = 4'hE;

  // system status bytes
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_QFRAME   = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONTINUE = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;
  localparam logic [7:0] ST_META     = 8'hFF;

  localparam int unsigned LEN_W   = 21;
  localparam int unsigned GROUP_W = 7;
  localparam logic [1:0]  LAST_GROUP = 2'd2;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [13:0] wide_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } result_t;

  function automatic logic [6:0] clamp7(input logic [7:0] b);
    clamp7 = b[7] ? 7'h7F : b[6:0];
  endfunction

endpackage

@@ rtl/mbsp_if.sv @@
// channel interfaces: byte input and parsed event output
interface mbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [3:0]  channel;
  logic [6:0]  data_one;
  logic [6:0]  data_two;
  logic [13:0] wide_value;
  logic [7:0]  payload_byte;
  logic        payload_last;

  modport source (output valid, output event_kind, output channel, output data_one,
                  output data_two, output wide_value, output payload_byte,
                  output payload_last, input ready);
  modport sink   (input valid, input event_kind, input channel, input data_one,
                  input data_two, input wide_value, input payload_byte,
                  input payload_last, output ready);
endinterface

@@ rtl/mbsp_in_reg.sv @@
// input register stage holding one received byte
module mbsp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       hold_valid,
  output logic [7:0] hold_byte,
  input  logic       advance
);
  import mbsp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end
endmodule

@@ rtl/mbsp_decode.sv @@
// parser state and per-byte decode
module mbsp_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        rx_byte,
  input  logic              fire,
  output logic              res_valid,
  output mbsp_pkg::result_t res
);
  import mbsp_pkg::*;

  logic [7:0]       status_r, status_nxt;
  phase_t           phase_r, phase_nxt;
  logic [6:0]       held_r, held_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [1:0]       groups_r, groups_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;

  logic [6:0]       clamped;
  logic             len_cont;
  logic [LEN_W-1:0] acc_base;
  logic [1:0]       groups_base;
  logic [LEN_W-1:0] acc_new;
  logic             len_done;
  logic [1:0]       groups_new;
  logic [LEN_W-1:0] remain_dec;
  logic             sx_len;

  assign clamped     = clamp7(rx_byte);
  // a length prefix continues only in the length phases, else it starts from zero
  assign len_cont    = (phase_r == PH_SX_LEN) || (phase_r == PH_META_LEN);
  assign acc_base    = len_cont ? acc_r : '0;
  assign groups_base = len_cont ? groups_r : 2'd0;
  assign acc_new     = {acc_base[LEN_W-GROUP_W-1:0], rx_byte[6:0]};
  assign len_done    = !(rx_byte[7] && (groups_base < LAST_GROUP));
  assign groups_new  = len_done ? 2'd0 : groups_base + 2'd1;
  assign remain_dec  = remain_r - LEN_W'(1);

  always_comb begin
    status_nxt = status_r;
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    acc_nxt    = acc_r;
    groups_nxt = groups_r;
    remain_nxt = remain_r;
    res_valid  = 1'b0;
    res        = '0;
    sx_len     = 1'b0;

    case (phase_r)
      PH_PAIR: begin
        phase_nxt    = PH_IDLE;
        res.channel  = status_r[3:0];
        res.data_one = held_r;
        res.data_two = clamped;
        case (status_r[7:4])
          NIB_NOTE_OFF: begin
            res_valid      = 1'b1;
            res.event_kind = EV_NOTE_OFF;
          end
          NIB_NOTE_ON: begin
            res_valid      = 1'b1;
            res.event_kind = EV_NOTE_ON;
          end
          NIB_NOTE_PRESS: begin
            res_valid      = 1'b1;
            res.event_kind = EV_NOTE_PRESS;
          end
          NIB_CC: begin
            res_valid      = 1'b1;
            res.event_kind = EV_CC;
          end
          NIB_BEND: begin
            res_valid      = 1'b1;
            res.event_kind = EV_BEND;
            res.wide_value = {clamped, held_r};
          end
          default: begin
            res.channel = 4'd0;
            if (status_r == ST_SONG_POS) begin
              res_valid      = 1'b1;
              res.event_kind = EV_SONG_POS;
              res.wide_value = {clamped, held_r};
            end
          end
        endcase
      end
      PH_SX_LEN: begin
        sx_len = 1'b1;
      end
      PH_SX_PAY: begin
        remain_nxt       = remain_dec;
        res_valid        = 1'b1;
        res.event_kind   = EV_SX_BYTE;
        res.payload_byte = rx_byte;
        res.payload_last = (remain_dec == '0);
        if (remain_dec == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_META_TYPE: begin
        acc_nxt    = '0;
        groups_nxt = 2'd0;
        phase_nxt  = PH_META_LEN;
      end
      PH_META_LEN: begin
        acc_nxt    = acc_new;
        groups_nxt = groups_new;
        if (len_done) begin
          if (acc_new == '0) begin
            phase_nxt = PH_IDLE;
          end else begin
            remain_nxt = acc_new;
            phase_nxt  = PH_META_SKIP;
          end
        end
      end
      PH_META_SKIP: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (rx_byte[7]) begin
          status_nxt = rx_byte;
          case (rx_byte)
            ST_SYSEX: begin
              acc_nxt    = '0;
              groups_nxt = 2'd0;
              phase_nxt  = PH_SX_LEN;
            end
            ST_META: begin
              phase_nxt = PH_META_TYPE;
            end
            ST_TUNE: begin
              res_valid      = 1'b1;
              res.event_kind = EV_TUNE;
            end
            ST_START: begin
              res_valid      = 1'b1;
              res.event_kind = EV_START;
            end
            ST_CONTINUE: begin
              res_valid      = 1'b1;
              res.event_kind = EV_CONTINUE;
            end
            ST_STOP: begin
              res_valid      = 1'b1;
              res.event_kind = EV_STOP;
            end
            default: begin
            end
          endcase
        end else begin
          // data byte under running status
          case (status_r[7:4])
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_NOTE_PRESS, NIB_CC, NIB_BEND: begin
              held_nxt  = clamped;
              phase_nxt = PH_PAIR;
            end
            NIB_PROG: begin
              res_valid      = 1'b1;
              res.event_kind = EV_PROG;
              res.channel    = status_r[3:0];
              res.data_one   = clamped;
            end
            NIB_CHAN_PRESS: begin
              res_valid      = 1'b1;
              res.event_kind = EV_CHAN_PRESS;
              res.channel    = status_r[3:0];
              res.data_one   = clamped;
            end
            default: begin
              case (status_r)
                ST_SYSEX: begin
                  sx_len = 1'b1;
                end
                ST_QFRAME: begin
                  res_valid      = 1'b1;
                  res.event_kind = EV_QFRAME;
                  res.data_one   = {4'd0, rx_byte[6:4]};
                  res.data_two   = {3'd0, rx_byte[3:0]};
                end
                ST_SONG_POS: begin
                  held_nxt  = clamped;
                  phase_nxt = PH_PAIR;
                end
                ST_SONG_SEL: begin
                  res_valid      = 1'b1;
                  res.event_kind = EV_SONG_SEL;
                  res.data_one   = clamped;
                end
                ST_META: begin
                  acc_nxt    = '0;
                  groups_nxt = 2'd0;
                  phase_nxt  = PH_META_LEN;
                end
                default: begin
                end
              endcase
            end
          endcase
        end
      end
    endcase

    // sysex length prefix byte, from the length phase or as the first data byte
    if (sx_len) begin
      acc_nxt    = acc_new;
      groups_nxt = groups_new;
      if (!len_done) begin
        phase_nxt = PH_SX_LEN;
      end else if (acc_new == '0) begin
        phase_nxt        = PH_IDLE;
        res_valid        = 1'b1;
        res.event_kind   = EV_SX_EMPTY;
        res.payload_last = 1'b1;
      end else begin
        remain_nxt = acc_new;
        phase_nxt  = PH_SX_PAY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      phase_r  <= PH_IDLE;
      held_r   <= '0;
      acc_r    <= '0;
      groups_r <= '0;
      remain_r <= '0;
    end else if (fire) begin
      status_r <= status_nxt;
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      acc_r    <= acc_nxt;
      groups_r <= groups_nxt;
      remain_r <= remain_nxt;
    end
  end
endmodule

@@ rtl/mbsp_out_reg.sv @@
// result register feeding the event channel
module mbsp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mbsp_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output mbsp_pkg::result_t out_res
);
  import mbsp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end
endmodule

@@ rtl/midi_byte_stream_parser.sv @@
// top level of the midi byte stream parser
//
//   channel   dir  payload                                     transfer when
//   in_bus    in   rx_byte                                     valid && ready
//   out_bus   out  event_kind channel data_one data_two        valid && ready
//                  wide_value payload_byte payload_last
//
// one byte per cycle while the output register does not stall: a byte is registered in the
// input register and decoded there, and its event, if any, is registered in the output
// register when the byte moves on.
// a byte that makes no event moves on even while the output register is stalled;
// one that makes an event waits in the input register until the output frees.
// synchronous active-low reset clears the stored status and returns to idle.
module midi_byte_stream_parser (
  input logic         clk,
  input logic         rst_n,
  mbsp_in_if.sink     in_bus,
  mbsp_out_if.source  out_bus
);
  import mbsp_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       out_free;
  result_t    out_res;

  mbsp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_byte    (in_bus.rx_byte),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .advance    (advance)
  );

  mbsp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (hold_byte),
    .fire      (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  assign advance = hold_valid && (!res_valid || out_free);

  mbsp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  assign out_bus.event_kind   = out_res.event_kind;
  assign out_bus.channel      = out_res.channel;
  assign out_bus.data_one     = out_res.data_one;
  assign out_bus.data_two     = out_res.data_two;
  assign out_bus.wide_value   = out_res.wide_value;
  assign out_bus.payload_byte = out_res.payload_byte;
  assign out_bus.payload_last = out_res.payload_last;
endmodule
